@@ rtl/cbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// cbpg_pkg: shared constants and types of the cubic bezier point generator
// widths of the curve parameter, the bernstein weights and the accumulators,
// register index codes and the controller to datapath command and status
// ----------------------------------------------------------------------------
package cbpg_pkg;

    // number of steps along the curve, t runs 0 .. STEPS
    localparam int STEPS   = 1000;
    localparam int T_W     = 10;
    localparam int COORD_W = 16;

    // curve parameter u in q1.16, 0 .. 1.0 inclusive
    localparam int FRAC_Q  = 16;
    localparam int U_W     = FRAC_Q + 1;
    localparam int ONE_Q16 = 1 << FRAC_Q;

    // per-step increment of u, whole part and remainder over STEPS
    localparam int INC_Q = ONE_Q16 / STEPS;
    localparam int INC_R = ONE_Q16 % STEPS;

    // squares are q.32, cubes and weights q.48
    localparam int SQ_W   = 2 * FRAC_Q + 1;
    localparam int FRAC_W = 3 * FRAC_Q;
    localparam int W_W    = FRAC_W + 1;

    // weights are split into two halves for the coordinate products
    localparam int WL_W = 24;
    localparam int WH_W = W_W - WL_W;
    localparam int PH_W = WH_W + 1 + COORD_W;
    localparam int PL_W = WL_W + 1 + COORD_W;

    // weighted sum, magnitude at most 2^63
    localparam int ACC_W = FRAC_W + COORD_W + 2;

    localparam int NUM_PTS = 4;
    localparam int SEL_W   = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // register index codes
    localparam logic [IDX_W-1:0] REG_P0_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_P0_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_P1_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_P1_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_P2_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_P2_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_P3_X = 3'd6;
    localparam logic [IDX_W-1:0] REG_P3_Y = 3'd7;

    typedef struct packed {
        logic             load;
        logic             restart;
        logic             square;
        logic             cube;
        logic             weigh;
        logic             mul;
        logic [SEL_W-1:0] sel;
        logic             accum;
        logic             fin;
    } cbpg_cmd_t;

    typedef struct packed {
        logic out_free;
    } cbpg_status_t;

endpackage

@@ rtl/cbpg_channels.sv @@
// ----------------------------------------------------------------------------
// cbpg channels: valid/ready interfaces of the cubic bezier point generator
// step requests in, curve points out, and the control point write port
// ----------------------------------------------------------------------------
interface cbpg_step_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface cbpg_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [cbpg_pkg::COORD_W-1:0] point_x;
    logic signed [cbpg_pkg::COORD_W-1:0] point_y;
    logic        [cbpg_pkg::T_W-1:0]     step_index;
    logic                                last;

    modport source (output valid, output point_x, output point_y, output step_index,
                    output last, input ready);
    modport sink   (input valid, input point_x, input point_y, input step_index,
                    input last, output ready);
endinterface

interface cbpg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cbpg_pkg::IDX_W-1:0]        index;
    logic [cbpg_pkg::DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cbpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbpg_ctrl: sequencer of the cubic bezier point generator
// takes one step request at a time and walks the datapath through its phases
// ----------------------------------------------------------------------------
module cbpg_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    cbpg_step_if.sink              step,
    output cbpg_pkg::cbpg_cmd_t    cmd,
    input  cbpg_pkg::cbpg_status_t status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_CUBE = 3'd2;
    localparam logic [2:0] ST_WGT  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [cbpg_pkg::SEL_W-1:0] sel_reg;
    logic [cbpg_pkg::SEL_W-1:0] sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        step.ready = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (step.valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.restart = step.restart;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                cmd.cube   = 1'b1;
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                cmd.weigh  = 1'b1;
                sel_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // products of the previous weight are summed while the next is formed
                cmd.mul   = 1'b1;
                cmd.accum = (sel_reg != '0);
                if (sel_reg == cbpg_pkg::SEL_W'(cbpg_pkg::NUM_PTS - 1))
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

@@ rtl/cbpg_datapath.sv @@
// ----------------------------------------------------------------------------
// cbpg_datapath: step counter, weight unit, product unit and output register
// holds the control points and forms one curve point per request
// ----------------------------------------------------------------------------
module cbpg_datapath
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cbpg_pkg::cbpg_cmd_t     cmd,
    output cbpg_pkg::cbpg_status_t  status,
    cbpg_cfg_if.sink                cfg,
    cbpg_point_if.source            point
);

    localparam int T_W     = cbpg_pkg::T_W;
    localparam int U_W     = cbpg_pkg::U_W;
    localparam int SQ_W    = cbpg_pkg::SQ_W;
    localparam int W_W     = cbpg_pkg::W_W;
    localparam int WL_W    = cbpg_pkg::WL_W;
    localparam int WH_W    = cbpg_pkg::WH_W;
    localparam int PH_W    = cbpg_pkg::PH_W;
    localparam int PL_W    = cbpg_pkg::PL_W;
    localparam int ACC_W   = cbpg_pkg::ACC_W;
    localparam int FRAC_W  = cbpg_pkg::FRAC_W;
    localparam int COORD_W = cbpg_pkg::COORD_W;
    localparam int NUM_PTS = cbpg_pkg::NUM_PTS;

    // truncate the q.48 sum toward zero
    function automatic logic [COORD_W-1:0] trunc_point(input logic signed [ACC_W-1:0] acc);
        logic adj;
        adj = acc[ACC_W-1] & (|acc[FRAC_W-1:0]);
        return acc[FRAC_W+COORD_W-1:FRAC_W] + COORD_W'(adj);
    endfunction

    // control points
    logic signed [COORD_W-1:0] cp_x_reg [NUM_PTS];
    logic signed [COORD_W-1:0] cp_x_next [NUM_PTS];
    logic signed [COORD_W-1:0] cp_y_reg [NUM_PTS];
    logic signed [COORD_W-1:0] cp_y_next [NUM_PTS];

    // step counter with u = floor(t * 2^16 / STEPS) and its remainder
    logic [T_W-1:0] cnt_reg;
    logic [T_W-1:0] cnt_next;
    logic [U_W-1:0] ucnt_reg;
    logic [U_W-1:0] ucnt_next;
    logic [T_W-1:0] rcnt_reg;
    logic [T_W-1:0] rcnt_next;

    logic [T_W-1:0] t_sel;
    logic [U_W-1:0] u_sel;
    logic [T_W-1:0] r_sel;
    logic [T_W:0]   r_sum;

    // point being worked on
    logic [T_W-1:0]  t_reg;
    logic [T_W-1:0]  t_next;
    logic [U_W-1:0]  u_reg;
    logic [U_W-1:0]  u_next;
    logic [U_W-1:0]  v_reg;
    logic [U_W-1:0]  v_next;
    logic [SQ_W-1:0] u2_reg;
    logic [SQ_W-1:0] u2_next;
    logic [SQ_W-1:0] v2_reg;
    logic [SQ_W-1:0] v2_next;
    logic [W_W-1:0]  w0c_reg;
    logic [W_W-1:0]  w0c_next;
    logic [W_W-1:0]  w3c_reg;
    logic [W_W-1:0]  w3c_next;
    logic [W_W-1:0]  m1_reg;
    logic [W_W-1:0]  m1_next;
    logic [W_W-1:0]  m2_reg;
    logic [W_W-1:0]  m2_next;
    logic [W_W-1:0]  w_reg [NUM_PTS];
    logic [W_W-1:0]  w_next [NUM_PTS];

    logic [W_W-1:0]            w_cur;
    logic signed [WH_W:0]      wh_s;
    logic signed [WL_W:0]      wl_s;
    logic signed [COORD_W-1:0] px_cur;
    logic signed [COORD_W-1:0] py_cur;

    logic signed [PH_W-1:0]  ph_x_reg;
    logic signed [PH_W-1:0]  ph_x_next;
    logic signed [PL_W-1:0]  pl_x_reg;
    logic signed [PL_W-1:0]  pl_x_next;
    logic signed [PH_W-1:0]  ph_y_reg;
    logic signed [PH_W-1:0]  ph_y_next;
    logic signed [PL_W-1:0]  pl_y_reg;
    logic signed [PL_W-1:0]  pl_y_next;
    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic signed [ACC_W-1:0] acc_y_next;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_x_next;
    logic [COORD_W-1:0] out_y_reg;
    logic [COORD_W-1:0] out_y_next;
    logic [T_W-1:0]     out_t_reg;
    logic [T_W-1:0]     out_t_next;
    logic               out_last_reg;
    logic               out_last_next;

    assign cfg.ready       = 1'b1;
    assign status.out_free = !out_valid_reg || point.ready;

    // control point writes
    always_comb
    begin
        cp_x_next = cp_x_reg;
        cp_y_next = cp_y_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                cbpg_pkg::REG_P0_X: cp_x_next[0] = cfg.data;
                cbpg_pkg::REG_P0_Y: cp_y_next[0] = cfg.data;
                cbpg_pkg::REG_P1_X: cp_x_next[1] = cfg.data;
                cbpg_pkg::REG_P1_Y: cp_y_next[1] = cfg.data;
                cbpg_pkg::REG_P2_X: cp_x_next[2] = cfg.data;
                cbpg_pkg::REG_P2_Y: cp_y_next[2] = cfg.data;
                cbpg_pkg::REG_P3_X: cp_x_next[3] = cfg.data;
                cbpg_pkg::REG_P3_Y: cp_y_next[3] = cfg.data;
                default:            cp_x_next    = cp_x_reg;
            endcase
        end
    end

    // step counter: u advances by INC_Q plus a carry out of the remainder
    always_comb
    begin
        t_sel     = cmd.restart ? '0 : cnt_reg;
        u_sel     = cmd.restart ? '0 : ucnt_reg;
        r_sel     = cmd.restart ? '0 : rcnt_reg;
        r_sum     = {1'b0, r_sel} + (T_W + 1)'(cbpg_pkg::INC_R);
        cnt_next  = cnt_reg;
        ucnt_next = ucnt_reg;
        rcnt_next = rcnt_reg;
        if (cmd.load)
        begin
            if (t_sel == T_W'(cbpg_pkg::STEPS))
            begin
                cnt_next  = '0;
                ucnt_next = '0;
                rcnt_next = '0;
            end
            else if (r_sum >= (T_W + 1)'(cbpg_pkg::STEPS))
            begin
                cnt_next  = t_sel + 1'b1;
                ucnt_next = u_sel + U_W'(cbpg_pkg::INC_Q + 1);
                rcnt_next = T_W'(r_sum - (T_W + 1)'(cbpg_pkg::STEPS));
            end
            else
            begin
                cnt_next  = t_sel + 1'b1;
                ucnt_next = u_sel + U_W'(cbpg_pkg::INC_Q);
                rcnt_next = T_W'(r_sum);
            end
        end
    end

    // weight unit: squares, then cubes and mixed terms, then times three
    always_comb
    begin
        t_next   = t_reg;
        u_next   = u_reg;
        v_next   = v_reg;
        u2_next  = u2_reg;
        v2_next  = v2_reg;
        w0c_next = w0c_reg;
        w3c_next = w3c_reg;
        m1_next  = m1_reg;
        m2_next  = m2_reg;
        w_next   = w_reg;
        if (cmd.load)
        begin
            t_next = t_sel;
            u_next = u_sel;
            v_next = U_W'(cbpg_pkg::ONE_Q16) - u_sel;
        end
        if (cmd.square)
        begin
            u2_next = SQ_W'(u_reg) * SQ_W'(u_reg);
            v2_next = SQ_W'(v_reg) * SQ_W'(v_reg);
        end
        if (cmd.cube)
        begin
            w0c_next = W_W'(v2_reg) * W_W'(v_reg);
            w3c_next = W_W'(u2_reg) * W_W'(u_reg);
            m1_next  = W_W'(v2_reg) * W_W'(u_reg);
            m2_next  = W_W'(u2_reg) * W_W'(v_reg);
        end
        if (cmd.weigh)
        begin
            w_next[0] = w0c_reg;
            w_next[1] = m1_reg + {m1_reg[W_W-2:0], 1'b0};
            w_next[2] = m2_reg + {m2_reg[W_W-2:0], 1'b0};
            w_next[3] = w3c_reg;
        end
    end

    // product unit: one weight against both coordinates, in two halves
    always_comb
    begin
        w_cur     = w_reg[cmd.sel];
        wh_s      = $signed({1'b0, w_cur[W_W-1:WL_W]});
        wl_s      = $signed({1'b0, w_cur[WL_W-1:0]});
        px_cur    = cp_x_reg[cmd.sel];
        py_cur    = cp_y_reg[cmd.sel];
        ph_x_next = ph_x_reg;
        pl_x_next = pl_x_reg;
        ph_y_next = ph_y_reg;
        pl_y_next = pl_y_reg;
        if (cmd.mul)
        begin
            ph_x_next = PH_W'(wh_s) * PH_W'(px_cur);
            pl_x_next = PL_W'(wl_s) * PL_W'(px_cur);
            ph_y_next = PH_W'(wh_s) * PH_W'(py_cur);
            pl_y_next = PL_W'(wl_s) * PL_W'(py_cur);
        end
    end

    always_comb
    begin
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        if (cmd.weigh)
        begin
            acc_x_next = '0;
            acc_y_next = '0;
        end
        else if (cmd.accum)
        begin
            acc_x_next = acc_x_reg + (ACC_W'(ph_x_reg) <<< WL_W) + ACC_W'(pl_x_reg);
            acc_y_next = acc_y_reg + (ACC_W'(ph_y_reg) <<< WL_W) + ACC_W'(pl_y_reg);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_t_next     = out_t_reg;
        out_last_next  = out_last_reg;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
            out_x_next     = trunc_point(acc_x_reg);
            out_y_next     = trunc_point(acc_y_reg);
            out_t_next     = t_reg;
            out_last_next  = (t_reg == T_W'(cbpg_pkg::STEPS));
        end
        else if (point.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign point.valid      = out_valid_reg;
    assign point.point_x    = out_x_reg;
    assign point.point_y    = out_y_reg;
    assign point.step_index = out_t_reg;
    assign point.last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PTS; i++)
            begin
                cp_x_reg[i] <= '0;
                cp_y_reg[i] <= '0;
            end
            cnt_reg       <= '0;
            ucnt_reg      <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cp_x_reg      <= cp_x_next;
            cp_y_reg      <= cp_y_next;
            cnt_reg       <= cnt_next;
            ucnt_reg      <= ucnt_next;
            rcnt_reg      <= rcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        u2_reg       <= u2_next;
        v2_reg       <= v2_next;
        w0c_reg      <= w0c_next;
        w3c_reg      <= w3c_next;
        m1_reg       <= m1_next;
        m2_reg       <= m2_next;
        w_reg        <= w_next;
        ph_x_reg     <= ph_x_next;
        pl_x_reg     <= pl_x_next;
        ph_y_reg     <= ph_y_next;
        pl_y_reg     <= pl_y_next;
        acc_x_reg    <= acc_x_next;
        acc_y_reg    <= acc_y_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_t_reg    <= out_t_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ rtl/cubic_bezier_point_generator.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator: one point of a cubic bezier curve per request
// control points from the write port, points in q1.16 steps along the curve
// ----------------------------------------------------------------------------
// usage
//   cfg   : control points (index 0..7: p0_x, p0_y .. p3_y), always ready;
//           the user writes only while no request is in flight (unchecked)
//   step  : one request per curve point; restart set forces t back to 0
//   point : point_x, point_y, step_index t and last (t equals STEPS)
// timing
//   a request is taken only while the sequencer is idle; its point is
//   registered after the sequencer has gone through the squares, cubes and
//   times three of the weights, the shared product unit (one weight per
//   cycle against both coordinates), the last sum and the result; the next
//   request is taken in the same cycle that the point shows, so the block
//   takes no new request before it is through with the last one
//   a finished point waits in the output register while the sink stalls; the
//   sequencer then holds its next result and takes no new request
// reset
//   control points clear to 0, the step counter to t = 0, no point is pending
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator
(
    input  logic         clk,
    input  logic         rst_n,
    cbpg_step_if.sink    step,
    cbpg_point_if.source point,
    cbpg_cfg_if.sink     cfg
);

    // commands from the sequencer, output register state back
    cbpg_pkg::cbpg_cmd_t    cmd;
    cbpg_pkg::cbpg_status_t status;

    // sequencer: request handshake and phase order
    cbpg_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (cmd),
        .status (status)
    );

    // datapath: step counter, weights, products, sums and the output register
    cbpg_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .cfg    (cfg),
        .point  (point)
    );

endmodule

@@ rtl/cbpg_chk.sv @@
// ----------------------------------------------------------------------------
// cbpg_chk: port checker of the cubic bezier point generator
// watches the request and point channels and is bound to the top level
// ----------------------------------------------------------------------------
module cbpg_chk
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [cbpg_pkg::COORD_W-1:0] point_x,
    input logic signed [cbpg_pkg::COORD_W-1:0] point_y,
    input logic        [cbpg_pkg::T_W-1:0]     step_index,
    input logic                                last
);

    // a point stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("point dropped before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(point_x) && $stable(point_y)
            && $stable(step_index) && $stable(last))
        else $error("point changed while stalled");

    // last marks exactly the end of the curve
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (step_index == cbpg_pkg::T_W'(cbpg_pkg::STEPS))))
        else $error("last flag does not match step index");

    // a request keeps the block busy at least through the square and cube phases
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("request taken while the previous one is in flight");

endmodule

bind cubic_bezier_point_generator cbpg_chk u_cbpg_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (step.valid),
    .in_ready   (step.ready),
    .out_valid  (point.valid),
    .out_ready  (point.ready),
    .point_x    (point.point_x),
    .point_y    (point.point_y),
    .step_index (point.step_index),
    .last       (point.last)
);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: cubic bezier point generator
// loads sets of control points through the write port and sends step requests.
// a local copy of the step counter and a fixed point curve evaluator predict
// every point, and each point that comes out is checked field by field.
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF    = 10;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 500000;

    // weights are q.48, this is 1.0 in that format
    localparam logic signed [79:0] WEIGHT_ONE = 80'sd1 << cbpg_pkg::FRAC_W;

    typedef struct {
        logic signed [cbpg_pkg::COORD_W-1:0] x;
        logic signed [cbpg_pkg::COORD_W-1:0] y;
        logic        [cbpg_pkg::T_W-1:0]     t;
        logic                                last;
    } curve_point_t;

    logic clk;
    logic rst_n;

    cbpg_step_if  step_ch ();
    cbpg_point_if point_ch ();
    cbpg_cfg_if   cfg_ch ();

    cubic_bezier_point_generator u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step_ch),
        .point (point_ch),
        .cfg   (cfg_ch)
    );

    // restart bits of the requests still to be sent
    logic         step_queue [$];
    // predicted points, oldest first
    curve_point_t expected_points [$];

    // shadow copy of the control point registers and of the step counter
    logic [cbpg_pkg::DATA_W-1:0] ctrl_reg [8];
    int unsigned                 next_t = 0;

    bit idle_on = 1'b1;
    int mismatches = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // cycle counter, ends a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // evaluates the curve at the current step index and advances the counter
    function automatic curve_point_t advance_curve(input logic restart);
        int unsigned        t;
        longint unsigned    u;
        longint unsigned    v;
        logic [63:0]        wt [4];
        logic signed [79:0] sum_x;
        logic signed [79:0] sum_y;
        logic signed [79:0] q_x;
        logic signed [79:0] q_y;
        curve_point_t       pt;
        t = restart ? 0 : next_t;
        // a counter past the end is clamped, cannot happen in practice
        if (t > cbpg_pkg::STEPS)
            t = cbpg_pkg::STEPS;
        // u in q1.16, exactly 1.0 at the last step
        u = (64'(t) * cbpg_pkg::ONE_Q16) / cbpg_pkg::STEPS;
        v = cbpg_pkg::ONE_Q16 - u;
        // bernstein weights, exact in q.48
        wt[0] = v * v * v;
        wt[1] = 3 * v * v * u;
        wt[2] = 3 * v * u * u;
        wt[3] = u * u * u;
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < cbpg_pkg::NUM_PTS; k++)
        begin
            sum_x = sum_x + $signed({1'b0, wt[k]}) * $signed(ctrl_reg[2 * k]);
            sum_y = sum_y + $signed({1'b0, wt[k]}) * $signed(ctrl_reg[2 * k + 1]);
        end
        // signed division truncates toward zero
        q_x = sum_x / WEIGHT_ONE;
        q_y = sum_y / WEIGHT_ONE;
        pt.x    = q_x[cbpg_pkg::COORD_W-1:0];
        pt.y    = q_y[cbpg_pkg::COORD_W-1:0];
        pt.t    = t[cbpg_pkg::T_W-1:0];
        pt.last = (t >= cbpg_pkg::STEPS);
        // wrap after the last point
        next_t = pt.last ? 0 : ((t + 1) % (1 << cbpg_pkg::T_W));
        return pt;
    endfunction

    // control point shadow, follows every accepted register write
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            ctrl_reg[cfg_ch.index] <= cfg_ch.data;
    end

    // request driver: presents queued requests, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ch.valid   <= 1'b0;
            step_ch.restart <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            // request taken at this edge, predict its point
            if (step_ch.valid && step_ch.ready)
                expected_points.push_back(advance_curve(step_ch.restart));
            if (!step_ch.valid || step_ch.ready)
            begin
                if (send_gap == 0 && idle_on && $urandom_range(7) == 0)
                    send_gap = $urandom_range(12, 1);
                if (send_gap > 0 || step_queue.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    step_ch.valid   <= 1'b0;
                    // payload is don't care while idle, keep it moving
                    step_ch.restart <= 1'($urandom_range(1, 0));
                end
                else
                begin
                    step_ch.valid   <= 1'b1;
                    step_ch.restart <= step_queue.pop_front();
                end
            end
        end
    end

    // point monitor: checks each accepted point, stalls in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t want;
        if (!rst_n)
        begin
            point_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                if (expected_points.size() == 0)
                    report_error($sformatf("point with no request pending, t %0d",
                                           point_ch.step_index));
                else
                begin
                    want = expected_points.pop_front();
                    if (point_ch.point_x !== want.x)
                        report_error($sformatf("t %0d point_x got %0d want %0d",
                                               want.t, point_ch.point_x, want.x));
                    if (point_ch.point_y !== want.y)
                        report_error($sformatf("t %0d point_y got %0d want %0d",
                                               want.t, point_ch.point_y, want.y));
                    if (point_ch.step_index !== want.t)
                        report_error($sformatf("step_index got %0d want %0d",
                                               point_ch.step_index, want.t));
                    if (point_ch.last !== want.last)
                        report_error($sformatf("t %0d last got %0b want %0b",
                                               want.t, point_ch.last, want.last));
                end
            end
            if (recv_stall == 0 && idle_on && $urandom_range(7) == 0)
                recv_stall = $urandom_range(12, 1);
            if (recv_stall > 0)
            begin
                recv_stall--;
                point_ch.ready <= 1'b0;
            end
            else
                point_ch.ready <= 1'b1;
        end
    end

    // one register write, entered and left at a rising edge
    task automatic write_reg(input logic [cbpg_pkg::IDX_W-1:0] idx,
                             input logic [cbpg_pkg::DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // loads all four control points while the block is idle
    task automatic load_curve(input logic [cbpg_pkg::DATA_W-1:0] x0, y0, x1, y1,
                              x2, y2, x3, y3);
        write_reg(cbpg_pkg::REG_P0_X, x0);
        write_reg(cbpg_pkg::REG_P0_Y, y0);
        write_reg(cbpg_pkg::REG_P1_X, x1);
        write_reg(cbpg_pkg::REG_P1_Y, y1);
        write_reg(cbpg_pkg::REG_P2_X, x2);
        write_reg(cbpg_pkg::REG_P2_Y, y2);
        write_reg(cbpg_pkg::REG_P3_X, x3);
        write_reg(cbpg_pkg::REG_P3_Y, y3);
        cfg_ch.valid <= 1'b0;
    endtask

    // waits until every request is sent and every point checked
    // sampled at the falling edge, after the driver and monitor have settled
    task automatic drain();
        do
            @(negedge clk);
        while (!(step_queue.size() == 0 && !step_ch.valid && expected_points.size() == 0));
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [cbpg_pkg::DATA_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom_range(16'hffff, 0));
        endcase
    endfunction

    task automatic queue_steps(input int count, input int restart_odds);
        for (int i = 0; i < count; i++)
            step_queue.push_back(restart_odds > 0 && $urandom_range(restart_odds - 1) == 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        step_ch.valid   = 1'b0;
        step_ch.restart = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = cbpg_pkg::REG_P0_X;
        cfg_ch.data     = '0;
        point_ch.ready  = 1'b0;
        for (int i = 0; i < 8; i++)
            ctrl_reg[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // control points at their reset value, curve collapses to the origin
        step_queue = '{1'b0, 1'b0, 1'b1, 1'b0};
        drain();

        // alternating extremes, largest swing of every weight
        load_curve(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                   16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        step_queue = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
        drain();

        // all points at the top and at the bottom of the range
        load_curve(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                   16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        step_queue = '{1'b0, 1'b1, 1'b0, 1'b0};
        drain();
        load_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h8000);
        step_queue = '{1'b0, 1'b0, 1'b1, 1'b0};
        drain();

        // straight line from one corner to the other, negative truncation
        load_curve(16'h8000, 16'hffff, 16'h7fff, 16'h0001,
                   16'h8000, 16'hffff, 16'h7fff, 16'h0001);
        step_queue = '{1'b1, 1'b0, 1'b0, 1'b0};
        drain();

        // random curves, restarts now and then
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_on = (ph != 2);
            load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       pick_coord(), pick_coord(), pick_coord(), pick_coord());
            queue_steps(110, 40);
            drain();
        end

        // closing stretch at full rate
        idle_on = 1'b0;
        load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), pick_coord(), pick_coord(), pick_coord());
        queue_steps(120, 20);
        drain();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cbpg_pkg.sv
rtl/cbpg_channels.sv
rtl/cbpg_ctrl.sv
rtl/cbpg_datapath.sv
rtl/cubic_bezier_point_generator.sv
rtl/cbpg_chk.sv
test/testbench.sv
